@@ hw/rtl/tenf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tenf_pkg
// Types, constants and Q16.16 helper functions shared by the triangle
// configurational force datapath.
// ----------------------------------------------------------------------------
package tenf_pkg;

    localparam int DATA_W      = 32;
    localparam int VAL_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = 64;
    localparam int MUL_LAT     = 3;
    localparam int DIV_STEP    = 2;
    localparam int DIV_STAGES  = QUO_W / DIV_STEP;
    localparam int DIV_LAT     = DIV_STAGES;
    localparam int CFG_INDEX_W = 4;
    localparam int NUM_VERTS   = 3;

    localparam logic [1:0] VERT_LAST = 2'd2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [VAL_W-1:0]        mag_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_C_NORMAL   = 4'd0,
        CFG_C_COUPLING = 4'd1,
        CFG_C_SHEAR    = 4'd2,
        CFG_MIN_AREA   = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x0;
        logic signed [DATA_W-1:0] y0;
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] y2;
        logic signed [DATA_W-1:0] ux0;
        logic signed [DATA_W-1:0] uy0;
        logic signed [DATA_W-1:0] ux1;
        logic signed [DATA_W-1:0] uy1;
        logic signed [DATA_W-1:0] ux2;
        logic signed [DATA_W-1:0] uy2;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]              vertex_index;
        logic signed [VAL_W-1:0] force_x;
        logic signed [VAL_W-1:0] force_y;
        logic                    degenerate;
        logic                    last;
    } out_beat_t;

    function automatic val_t sat48(input logic signed [VAL_W+1:0] v);
        logic signed [VAL_W+1:0] vmax;
        logic signed [VAL_W+1:0] vmin;
        vmax = 50'sd140737488355327;
        vmin = -50'sd140737488355328;
        if (v > vmax)
        begin
            return vmax[VAL_W-1:0];
        end
        if (v < vmin)
        begin
            return vmin[VAL_W-1:0];
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W+1:0] ext50(input val_t v);
        return {{2{v[VAL_W-1]}}, v};
    endfunction

    function automatic val_t sum2(input val_t a, input val_t b);
        return sat48(ext50(a) + ext50(b));
    endfunction

    function automatic val_t sum3(input val_t a, input val_t b, input val_t c);
        return sat48(ext50(a) + ext50(b) + ext50(c));
    endfunction

    function automatic val_t diff2(input val_t a, input val_t b);
        return sat48(ext50(a) - ext50(b));
    endfunction

    // halve, truncating toward zero
    function automatic val_t half_trunc(input val_t v);
        logic [VAL_W:0] t;
        t = {v[VAL_W-1], v} + {{VAL_W{1'b0}}, v[VAL_W-1]};
        return t[VAL_W:1];
    endfunction

    function automatic mag_t mag48(input val_t v);
        mag_t u;
        u = v;
        return v[VAL_W-1] ? (~u + 48'd1) : u;
    endfunction

    function automatic val_t limit48(input logic [QUO_W-1:0] q, input logic neg);
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] qc;
        mag_t             m;
        lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
        qc  = (q > lim) ? lim : q;
        m   = qc[VAL_W-1:0];
        return neg ? (~m + 48'd1) : m;
    endfunction

endpackage

@@ hw/rtl/tenf_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tenf_delay
// Enabled shift line that carries side data and valid bits alongside the
// arithmetic stages.
// ----------------------------------------------------------------------------
module tenf_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dl_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            dl_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    assign q = dl_reg[DEPTH-1];

endmodule

@@ hw/rtl/tenf_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tenf_mul
// Three-stage Q16.16 multiplier on 48-bit operands: partial products,
// product sum, then round half away from zero and saturate to 48 bits.
// ----------------------------------------------------------------------------
module tenf_mul (
    input  logic           clk,
    input  logic           en,
    input  tenf_pkg::val_t a,
    input  tenf_pkg::val_t b,
    output tenf_pkg::val_t p
);

    tenf_pkg::mag_t ma;
    tenf_pkg::mag_t mb;

    logic        neg1_reg;
    logic [63:0] p00_reg;
    logic [47:0] p01_reg;
    logic [47:0] p10_reg;
    logic [31:0] p11_reg;

    logic        neg2_reg;
    logic [95:0] prod_reg;

    logic [96:0] rnd;
    logic [80:0] q81;
    logic [63:0] q64;

    tenf_pkg::val_t p_reg;

    assign ma = tenf_pkg::mag48(a);
    assign mb = tenf_pkg::mag48(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a[47] ^ b[47];
            p00_reg  <= ma[31:0] * mb[31:0];
            p01_reg  <= ma[31:0] * mb[47:32];
            p10_reg  <= ma[47:32] * mb[31:0];
            p11_reg  <= ma[47:32] * mb[47:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg <= neg1_reg;
            prod_reg <= {32'b0, p00_reg}
                      + {16'b0, p01_reg, 32'b0}
                      + {16'b0, p10_reg, 32'b0}
                      + {p11_reg, 64'b0};
        end
    end

    always_comb
    begin
        rnd = {1'b0, prod_reg} + 97'h8000;
        q81 = rnd[96:16];
        q64 = (|q81[80:64]) ? {64{1'b1}} : q81[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= tenf_pkg::limit48(q64, neg2_reg);
        end
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/tenf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tenf_div
// Pipelined restoring divider: (num << 16) / den on magnitudes, two
// quotient bits per stage.
// ----------------------------------------------------------------------------
module tenf_div (
    input  logic                          clk,
    input  logic                          en,
    input  tenf_pkg::mag_t                num,
    input  tenf_pkg::mag_t                den,
    output logic [tenf_pkg::QUO_W-1:0]    quo
);

    localparam int STAGES = tenf_pkg::DIV_STAGES;
    localparam int STEP   = tenf_pkg::DIV_STEP;
    localparam int QW     = tenf_pkg::QUO_W;
    localparam int VW     = tenf_pkg::VAL_W;

    logic [VW-1:0] rem_reg [STAGES];
    logic [QW-1:0] nq_reg  [STAGES];
    logic [VW-1:0] den_reg [STAGES];

    genvar gs;
    generate
        for (gs = 0; gs < STAGES; gs++)
        begin : g_stage
            logic [VW-1:0] rem_in;
            logic [QW-1:0] nq_in;
            logic [VW-1:0] den_in;
            logic [VW-1:0] rem_next;
            logic [QW-1:0] nq_next;

            if (gs == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = {num, {tenf_pkg::FRAC_W{1'b0}}};
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[gs-1];
                assign nq_in  = nq_reg[gs-1];
                assign den_in = den_reg[gs-1];
            end

            always_comb
            begin
                logic [VW:0]   t;
                logic [VW-1:0] r;
                logic [QW-1:0] n;
                r = rem_in;
                n = nq_in;
                for (int j = 0; j < STEP; j++)
                begin
                    t = {r, n[QW-1]};
                    n = {n[QW-2:0], 1'b0};
                    if (t >= {1'b0, den_in})
                    begin
                        t    = t - {1'b0, den_in};
                        n[0] = 1'b1;
                    end
                    r = t[VW-1:0];
                end
                rem_next = r;
                nq_next  = n;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[gs] <= rem_next;
                    nq_reg[gs]  <= nq_next;
                    den_reg[gs] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[STAGES-1];

endmodule

@@ hw/rtl/triangle_eshelby_node_force.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_eshelby_node_force
// Configurational force on the three vertices of a linear triangle.
// ----------------------------------------------------------------------------
// One triangle per input beat, three result beats out (vertex 0, 1, 2, last
// marked on vertex 2). The pipeline takes a triangle in any cycle it is not
// stalled; sustained throughput is bounded by the three result beats each
// triangle puts on the output channel. Most of the path from input beat to
// the first result beat is the 32-stage gradient divider. The whole pipeline
// stalls together when the output buffer is still busy and a result is
// waiting to enter it. Write the coefficient registers only while the block
// is idle.
// ----------------------------------------------------------------------------
module triangle_eshelby_node_force #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tenf_pkg::in_beat_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tenf_pkg::out_beat_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tenf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tenf_pkg::DATA_W-1:0]          cfg_data
);

    localparam int CW  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int DW  = CW + 1;
    localparam int VW  = tenf_pkg::VAL_W;
    localparam int EXT = VW - DW;
    localparam int NV  = tenf_pkg::NUM_VERTS;

    localparam int ST_A  = 1;
    localparam int ST_M1 = ST_A + tenf_pkg::MUL_LAT;
    localparam int ST_B  = ST_M1 + 1;
    localparam int ST_C  = ST_B + 1;
    localparam int ST_DV = ST_C + tenf_pkg::DIV_LAT;
    localparam int ST_D  = ST_DV + 1;
    localparam int ST_E  = ST_D + 1;
    localparam int ST_M2 = ST_E + tenf_pkg::MUL_LAT;
    localparam int ST_F  = ST_M2 + 1;
    localparam int ST_M3 = ST_F + tenf_pkg::MUL_LAT;
    localparam int ST_G  = ST_M3 + 1;
    localparam int ST_H  = ST_G + 1;
    localparam int ST_M4 = ST_H + tenf_pkg::MUL_LAT;

    localparam int M1_N = 14;
    localparam int M2_N = 5;
    localparam int M3_N = 11;
    localparam int M4_N = 12;

    function automatic logic signed [DW-1:0] csub(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic tenf_pkg::val_t widen(input logic [DW-1:0] v);
        return {{EXT{v[DW-1]}}, v};
    endfunction

    function automatic tenf_pkg::val_t widen32(input logic [31:0] v);
        return {{(VW-32){v[31]}}, v};
    endfunction

    // configuration
    logic [31:0] c_normal_reg;
    logic [31:0] c_coupling_reg;
    logic [31:0] c_shear_reg;
    logic [31:0] min_area_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_normal_reg   <= '0;
            c_coupling_reg <= '0;
            c_shear_reg    <= '0;
            min_area_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tenf_pkg::CFG_C_NORMAL:   c_normal_reg   <= cfg_data;
                tenf_pkg::CFG_C_COUPLING: c_coupling_reg <= cfg_data;
                tenf_pkg::CFG_C_SHEAR:    c_shear_reg    <= cfg_data;
                tenf_pkg::CFG_MIN_AREA:   min_area_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    logic en;
    logic m4_vld;
    logic ob_free;

    // stage A: coordinate differences
    logic [CW-1:0] cx [NV];
    logic [CW-1:0] cy [NV];

    logic              a_vld_reg;
    logic [DW-1:0]     a_dx1_reg, a_dy2_reg, a_dx2_reg, a_dy1_reg;
    logic [DW-1:0]     a_b_reg [NV];
    logic [DW-1:0]     a_c_reg [NV];
    logic [31:0]       a_ux_reg [NV];
    logic [31:0]       a_uy_reg [NV];

    always_comb
    begin
        cx[0] = in_data.x0[CW-1:0];
        cy[0] = in_data.y0[CW-1:0];
        cx[1] = in_data.x1[CW-1:0];
        cy[1] = in_data.y1[CW-1:0];
        cx[2] = in_data.x2[CW-1:0];
        cy[2] = in_data.y2[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx1_reg   <= csub(cx[1], cx[0]);
            a_dy2_reg   <= csub(cy[2], cy[0]);
            a_dx2_reg   <= csub(cx[2], cx[0]);
            a_dy1_reg   <= csub(cy[1], cy[0]);
            a_b_reg[0]  <= csub(cy[1], cy[2]);
            a_b_reg[1]  <= csub(cy[2], cy[0]);
            a_b_reg[2]  <= csub(cy[0], cy[1]);
            a_c_reg[0]  <= csub(cx[2], cx[1]);
            a_c_reg[1]  <= csub(cx[0], cx[2]);
            a_c_reg[2]  <= csub(cx[1], cx[0]);
            a_ux_reg[0] <= in_data.ux0;
            a_uy_reg[0] <= in_data.uy0;
            a_ux_reg[1] <= in_data.ux1;
            a_uy_reg[1] <= in_data.uy1;
            a_ux_reg[2] <= in_data.ux2;
            a_uy_reg[2] <= in_data.uy2;
        end
    end

    // M1: area and gradient numerator products
    tenf_pkg::val_t m1_a [M1_N];
    tenf_pkg::val_t m1_b [M1_N];
    tenf_pkg::val_t m1_p [M1_N];

    always_comb
    begin
        m1_a[0] = widen(a_dx1_reg);
        m1_b[0] = widen(a_dy2_reg);
        m1_a[1] = widen(a_dx2_reg);
        m1_b[1] = widen(a_dy1_reg);
        for (int k = 0; k < NV; k++)
        begin
            m1_a[2+k]  = widen32(a_ux_reg[k]);
            m1_b[2+k]  = widen(a_b_reg[k]);
            m1_a[5+k]  = widen32(a_ux_reg[k]);
            m1_b[5+k]  = widen(a_c_reg[k]);
            m1_a[8+k]  = widen32(a_uy_reg[k]);
            m1_b[8+k]  = widen(a_b_reg[k]);
            m1_a[11+k] = widen32(a_uy_reg[k]);
            m1_b[11+k] = widen(a_c_reg[k]);
        end
    end

    // stage B: doubled area and numerator sums
    tenf_pkg::val_t b_d_reg;
    tenf_pkg::val_t b_sum_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_d_reg      <= tenf_pkg::diff2(m1_p[0], m1_p[1]);
            b_sum_reg[0] <= tenf_pkg::sum3(m1_p[2], m1_p[3], m1_p[4]);
            b_sum_reg[1] <= tenf_pkg::sum3(m1_p[5], m1_p[6], m1_p[7]);
            b_sum_reg[2] <= tenf_pkg::sum3(m1_p[8], m1_p[9], m1_p[10]);
            b_sum_reg[3] <= tenf_pkg::sum3(m1_p[11], m1_p[12], m1_p[13]);
        end
    end

    // stage C: degenerate test, magnitudes for the divider
    logic           c_degen_reg;
    logic           c_dpos_reg;
    tenf_pkg::mag_t c_den_reg;
    tenf_pkg::mag_t c_num_reg [4];
    logic [3:0]     c_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_degen_reg <= (b_d_reg == '0)
                        || (tenf_pkg::mag48(b_d_reg) < {15'b0, min_area_reg, 1'b0});
            c_dpos_reg  <= !b_d_reg[VW-1] && (b_d_reg != '0);
            c_den_reg   <= tenf_pkg::mag48(b_d_reg);
            for (int i = 0; i < 4; i++)
            begin
                c_num_reg[i] <= tenf_pkg::mag48(b_sum_reg[i]);
                c_neg_reg[i] <= b_sum_reg[i][VW-1] ^ b_d_reg[VW-1];
            end
        end
    end

    // gradient division
    logic [tenf_pkg::QUO_W-1:0] quo [4];
    logic [3:0]                 neg_dl;

    genvar gl;
    generate
        for (gl = 0; gl < 4; gl++)
        begin : g_div
            tenf_div u_div (
                .clk (clk),
                .en  (en),
                .num (c_num_reg[gl]),
                .den (c_den_reg),
                .quo (quo[gl])
            );
        end
    endgenerate

    tenf_delay #(.W(4), .DEPTH(tenf_pkg::DIV_LAT)) u_neg_dl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (c_neg_reg),
        .q     (neg_dl)
    );

    // stage D: signed gradient g00, g01, g10, g11
    tenf_pkg::val_t d_g_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d_g_reg[i] <= tenf_pkg::limit48(quo[i], neg_dl[i]);
            end
        end
    end

    // stage E: Voigt strain
    tenf_pkg::val_t e_e_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_e_reg[0] <= d_g_reg[0];
            e_e_reg[1] <= d_g_reg[3];
            e_e_reg[2] <= tenf_pkg::sum2(d_g_reg[1], d_g_reg[2]);
        end
    end

    // M2: stress products
    tenf_pkg::val_t m2_a [M2_N];
    tenf_pkg::val_t m2_b [M2_N];
    tenf_pkg::val_t m2_p [M2_N];
    tenf_pkg::val_t cn, cc, cs;

    always_comb
    begin
        cn = {16'b0, c_normal_reg};
        cc = {16'b0, c_coupling_reg};
        cs = {16'b0, c_shear_reg};
        m2_a[0] = cn; m2_b[0] = e_e_reg[0];
        m2_a[1] = cc; m2_b[1] = e_e_reg[1];
        m2_a[2] = cc; m2_b[2] = e_e_reg[0];
        m2_a[3] = cn; m2_b[3] = e_e_reg[1];
        m2_a[4] = cs; m2_b[4] = e_e_reg[2];
    end

    // stage F: stress
    tenf_pkg::val_t f_s_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_s_reg[0] <= tenf_pkg::sum2(m2_p[0], m2_p[1]);
            f_s_reg[1] <= tenf_pkg::sum2(m2_p[2], m2_p[3]);
            f_s_reg[2] <= m2_p[4];
        end
    end

    logic [3*VW-1:0] e_pk, e_dl;
    logic [4*VW-1:0] g_pk, g_dl;

    assign e_pk = {e_e_reg[2], e_e_reg[1], e_e_reg[0]};
    assign g_pk = {d_g_reg[3], d_g_reg[2], d_g_reg[1], d_g_reg[0]};

    tenf_delay #(.W(3*VW), .DEPTH(ST_F - ST_E)) u_e_dl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (e_pk),
        .q     (e_dl)
    );

    tenf_delay #(.W(4*VW), .DEPTH(ST_F - ST_D)) u_g_dl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (g_pk),
        .q     (g_dl)
    );

    // M3: energy and G^T sigma products
    tenf_pkg::val_t m3_a [M3_N];
    tenf_pkg::val_t m3_b [M3_N];
    tenf_pkg::val_t m3_p [M3_N];
    tenf_pkg::val_t ee [3];
    tenf_pkg::val_t gg [4];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ee[i] = e_dl[i*VW +: VW];
        end
        for (int i = 0; i < 4; i++)
        begin
            gg[i] = g_dl[i*VW +: VW];
        end
        m3_a[0]  = ee[0]; m3_b[0]  = f_s_reg[0];
        m3_a[1]  = ee[1]; m3_b[1]  = f_s_reg[1];
        m3_a[2]  = ee[2]; m3_b[2]  = f_s_reg[2];
        m3_a[3]  = gg[0]; m3_b[3]  = f_s_reg[0];
        m3_a[4]  = gg[2]; m3_b[4]  = f_s_reg[2];
        m3_a[5]  = gg[0]; m3_b[5]  = f_s_reg[2];
        m3_a[6]  = gg[2]; m3_b[6]  = f_s_reg[1];
        m3_a[7]  = gg[1]; m3_b[7]  = f_s_reg[0];
        m3_a[8]  = gg[3]; m3_b[8]  = f_s_reg[2];
        m3_a[9]  = gg[1]; m3_b[9]  = f_s_reg[2];
        m3_a[10] = gg[3]; m3_b[10] = f_s_reg[1];
    end

    // stage G: energy density and G^T sigma terms
    tenf_pkg::val_t g_w_reg;
    tenf_pkg::val_t g_t_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_w_reg    <= tenf_pkg::half_trunc(tenf_pkg::sum3(m3_p[0], m3_p[1], m3_p[2]));
            g_t_reg[0] <= tenf_pkg::sum2(m3_p[3], m3_p[4]);
            g_t_reg[1] <= tenf_pkg::sum2(m3_p[5], m3_p[6]);
            g_t_reg[2] <= tenf_pkg::sum2(m3_p[7], m3_p[8]);
            g_t_reg[3] <= tenf_pkg::sum2(m3_p[9], m3_p[10]);
        end
    end

    // stage H: Eshelby tensor S00, S01, S10, S11
    tenf_pkg::val_t h_s_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_s_reg[0] <= tenf_pkg::diff2(g_w_reg, g_t_reg[0]);
            h_s_reg[1] <= tenf_pkg::diff2('0, g_t_reg[1]);
            h_s_reg[2] <= tenf_pkg::diff2('0, g_t_reg[2]);
            h_s_reg[3] <= tenf_pkg::diff2(g_w_reg, g_t_reg[3]);
        end
    end

    logic [2*NV*DW-1:0] bc_pk, bc_dl;

    assign bc_pk = {a_c_reg[2], a_c_reg[1], a_c_reg[0],
                    a_b_reg[2], a_b_reg[1], a_b_reg[0]};

    tenf_delay #(.W(2*NV*DW), .DEPTH(ST_H - ST_A)) u_bc_dl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (bc_pk),
        .q     (bc_dl)
    );

    // M4: S . (b_k, c_k)
    tenf_pkg::val_t m4_a [M4_N];
    tenf_pkg::val_t m4_b [M4_N];
    tenf_pkg::val_t m4_p [M4_N];

    always_comb
    begin
        for (int k = 0; k < NV; k++)
        begin
            m4_a[4*k+0] = h_s_reg[0];
            m4_b[4*k+0] = widen(bc_dl[k*DW +: DW]);
            m4_a[4*k+1] = h_s_reg[1];
            m4_b[4*k+1] = widen(bc_dl[(NV+k)*DW +: DW]);
            m4_a[4*k+2] = h_s_reg[2];
            m4_b[4*k+2] = widen(bc_dl[k*DW +: DW]);
            m4_a[4*k+3] = h_s_reg[3];
            m4_b[4*k+3] = widen(bc_dl[(NV+k)*DW +: DW]);
        end
    end

    genvar gm;
    generate
        for (gm = 0; gm < M1_N; gm++)
        begin : g_m1
            tenf_mul u_mul (.clk(clk), .en(en), .a(m1_a[gm]), .b(m1_b[gm]), .p(m1_p[gm]));
        end
        for (gm = 0; gm < M2_N; gm++)
        begin : g_m2
            tenf_mul u_mul (.clk(clk), .en(en), .a(m2_a[gm]), .b(m2_b[gm]), .p(m2_p[gm]));
        end
        for (gm = 0; gm < M3_N; gm++)
        begin : g_m3
            tenf_mul u_mul (.clk(clk), .en(en), .a(m3_a[gm]), .b(m3_b[gm]), .p(m3_p[gm]));
        end
        for (gm = 0; gm < M4_N; gm++)
        begin : g_m4
            tenf_mul u_mul (.clk(clk), .en(en), .a(m4_a[gm]), .b(m4_b[gm]), .p(m4_p[gm]));
        end
    endgenerate

    // flags and valid to the output buffer
    logic [1:0] flag_dl;

    tenf_delay #(.W(2), .DEPTH(ST_M4 - ST_C)) u_flag_dl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     ({c_degen_reg, c_dpos_reg}),
        .q     (flag_dl)
    );

    tenf_delay #(.W(1), .DEPTH(ST_M4 - ST_A)) u_vld_dl (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (a_vld_reg),
        .q     (m4_vld)
    );

    // output buffer: one triangle, three beats
    logic           ob_vld_reg, ob_vld_next;
    logic [1:0]     ob_cnt_reg, ob_cnt_next;
    logic           ob_degen_reg;
    tenf_pkg::val_t ob_fx_reg [NV];
    tenf_pkg::val_t ob_fy_reg [NV];
    tenf_pkg::val_t t0 [NV];
    tenf_pkg::val_t t1 [NV];
    logic           out_fire;
    logic           load;

    assign out_fire = ob_vld_reg && out_ready;
    assign ob_free  = !ob_vld_reg || (out_ready && (ob_cnt_reg == tenf_pkg::VERT_LAST));
    assign en       = ob_free || !m4_vld;
    assign in_ready = en;
    assign load     = en && m4_vld;

    always_comb
    begin
        for (int k = 0; k < NV; k++)
        begin
            t0[k] = tenf_pkg::half_trunc(tenf_pkg::sum2(m4_p[4*k+0], m4_p[4*k+1]));
            t1[k] = tenf_pkg::half_trunc(tenf_pkg::sum2(m4_p[4*k+2], m4_p[4*k+3]));
        end
    end

    always_comb
    begin
        ob_vld_next = ob_vld_reg;
        ob_cnt_next = ob_cnt_reg;
        if (out_fire)
        begin
            if (ob_cnt_reg == tenf_pkg::VERT_LAST)
            begin
                ob_vld_next = 1'b0;
            end
            else
            begin
                ob_cnt_next = ob_cnt_reg + 2'd1;
            end
        end
        if (load)
        begin
            ob_vld_next = 1'b1;
            ob_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_vld_reg <= 1'b0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            ob_vld_reg <= ob_vld_next;
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ob_degen_reg <= flag_dl[1];
            for (int k = 0; k < NV; k++)
            begin
                if (flag_dl[1])
                begin
                    ob_fx_reg[k] <= '0;
                    ob_fy_reg[k] <= '0;
                end
                else if (flag_dl[0])
                begin
                    ob_fx_reg[k] <= tenf_pkg::diff2('0, t0[k]);
                    ob_fy_reg[k] <= tenf_pkg::diff2('0, t1[k]);
                end
                else
                begin
                    ob_fx_reg[k] <= t0[k];
                    ob_fy_reg[k] <= t1[k];
                end
            end
        end
    end

    assign out_valid             = ob_vld_reg;
    assign out_data.vertex_index = ob_cnt_reg;
    assign out_data.force_x      = ob_fx_reg[ob_cnt_reg];
    assign out_data.force_y      = ob_fy_reg[ob_cnt_reg];
    assign out_data.degenerate   = ob_degen_reg;
    assign out_data.last         = (ob_cnt_reg == tenf_pkg::VERT_LAST);

endmodule
